// ===== rtl/rutcdv_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the rut check digit validator
// no dependencies; used by rut_check_digit_validator
package rutcdv_pkg;

    localparam int MAX_DIGITS = 10;

    // the six group sums stay small: at most ceil(MAX_DIGITS / 6) digits each
    localparam int GROUP_DIGITS = (MAX_DIGITS + 5) / 6;
    localparam int SUM_W        = $clog2(GROUP_DIGITS * 9 + 1);
    localparam int DCNT_W       = $clog2(MAX_DIGITS + 1);
    localparam int NUM_GROUPS   = 6;

    // weighted sum: weights 2..7 over the group sums
    localparam int WSUM_MAX     = 27 * GROUP_DIGITS * 9;
    localparam int WSUM_W       = $clog2(WSUM_MAX + 1);

    // mod 11 by reciprocal multiply; quotient is low by at most one
    localparam int RECIP_SHIFT  = WSUM_W + 4;
    localparam int RECIP        = (1 << RECIP_SHIFT) / 11;
    localparam int RECIP_W      = $clog2(RECIP + 1);
    localparam int PROD_W       = WSUM_W + RECIP_W;

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_K      = 8'h4B;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] CASE_DIFF = 8'h20;

    typedef struct packed {
        logic [7:0] char_in;
        logic       last;
    } t_in_beat;

    typedef struct packed {
        logic       valid_res;
        logic       format_ok;
        logic [3:0] check_value;
    } t_out_beat;

endpackage

// ===== rtl/rut_check_digit_validator.sv =====
`timescale 1ns / 1ps
// rut check digit validator: format parser, group sums and mod 11 check
// depends on rutcdv_pkg
//
// usage
//   input channel (i_in_valid / o_in_ready / i_in) carries one character
//   per beat, i_in.last marks the final character of a string. dots and
//   spaces are skipped. accepted form: optional '+', 1..MAX_DIGITS digits,
//   '-', one check character; anything after that is ignored.
//   output channel (o_out_valid / i_out_ready / o_out) carries one beat per
//   string, produced by the beat with last set; other beats give nothing.
// pipeline and throughput
//   the result of a string is registered in turn: the snapshot register
//   loads on the edge that accepts its last beat, then the weighted sum
//   register, then the result register.
//   one character is taken every cycle while the output side is free or
//   being drained; all three stages advance together.
// stall
//   while o_out_valid is high and i_out_ready low the whole pipe holds and
//   o_in_ready is low; the held result stays stable.
// reset
//   synchronous active low; parser returns to start, sums and digit count
//   clear, no result pending. the parser also returns to start after each
//   last beat.
module rut_check_digit_validator (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  rutcdv_pkg::t_in_beat  i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output rutcdv_pkg::t_out_beat o_out
);

    // parser phase codes; codes 6 and 7 behave as error
    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_SIGNED = 3'd1;
    localparam logic [2:0] PH_DIGITS = 3'd2;
    localparam logic [2:0] PH_HYPHEN = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;
    localparam logic [2:0] PH_ERROR  = 3'd5;

    localparam int SW = rutcdv_pkg::SUM_W;
    localparam int CW = rutcdv_pkg::DCNT_W;
    localparam int WW = rutcdv_pkg::WSUM_W;
    localparam int PW = rutcdv_pkg::PROD_W;
    localparam int NG = rutcdv_pkg::NUM_GROUPS;

    // parser state
    logic [2:0]    r_phase, n_phase;
    logic [SW-1:0] r_sums [NG];
    logic [SW-1:0] n_sums [NG];
    logic [CW-1:0] r_dcnt, n_dcnt;
    logic [7:0]    r_check, n_check;

    // stage 1: snapshot of a finished string
    logic          r_s1_valid;
    logic          r_s1_ok;
    logic [SW-1:0] r_s1_sums [NG];
    logic [7:0]    r_s1_check;

    // stage 2: weighted sum
    logic          r_s2_valid;
    logic          r_s2_ok;
    logic [WW-1:0] r_s2_wsum;
    logic [7:0]    r_s2_check;

    // result register
    logic                  r_out_valid;
    rutcdv_pkg::t_out_beat r_out;

    logic          w_adv;
    logic          w_accept;
    logic          w_is_digit;
    logic          w_skip;
    logic          w_take_digit;
    logic [3:0]    w_dval;
    logic [7:0]    w_upper;
    logic [WW-1:0] w_wsum;
    logic [PW-1:0] w_prod;
    logic [WW-1:0] w_quot;
    logic [4:0]    w_rem_raw;
    logic [3:0]    w_rem;
    logic [3:0]    w_cv;
    logic [7:0]    w_expect;

    // whole pipe moves when the result slot is free or being taken
    assign w_adv      = !r_out_valid || i_out_ready;
    assign o_in_ready = w_adv;
    assign w_accept   = i_in_valid && w_adv;

    assign w_is_digit = (i_in.char_in >= rutcdv_pkg::CH_ZERO) &&
                        (i_in.char_in <= rutcdv_pkg::CH_NINE);
    assign w_skip     = (i_in.char_in == rutcdv_pkg::CH_DOT) ||
                        (i_in.char_in == rutcdv_pkg::CH_SPACE);
    assign w_dval     = 4'(i_in.char_in - rutcdv_pkg::CH_ZERO);

    // next parser state for the incoming character
    always_comb begin
        n_phase      = r_phase;
        n_sums       = r_sums;
        n_dcnt       = r_dcnt;
        n_check      = r_check;
        w_take_digit = 1'b0;
        if (!w_skip) begin
            case (r_phase)
                PH_START: begin
                    if (i_in.char_in == rutcdv_pkg::CH_PLUS) begin
                        n_phase = PH_SIGNED;
                    end else if (w_is_digit) begin
                        w_take_digit = 1'b1;
                    end else begin
                        n_phase = PH_ERROR;
                    end
                end
                PH_SIGNED: begin
                    if (w_is_digit) begin
                        w_take_digit = 1'b1;
                    end else begin
                        n_phase = PH_ERROR;
                    end
                end
                PH_DIGITS: begin
                    if (w_is_digit) begin
                        w_take_digit = 1'b1;
                    end else if (i_in.char_in == rutcdv_pkg::CH_MINUS) begin
                        n_phase = PH_HYPHEN;
                    end else begin
                        n_phase = PH_ERROR;
                    end
                end
                PH_HYPHEN: begin
                    n_check = i_in.char_in;
                    n_phase = PH_DONE;
                end
                PH_DONE: begin
                    n_phase = PH_DONE;
                end
                default: begin
                    n_phase = PH_ERROR;
                end
            endcase
        end
        if (w_take_digit) begin
            if (r_dcnt >= CW'(rutcdv_pkg::MAX_DIGITS)) begin
                // too many digits
                n_phase = PH_ERROR;
            end else begin
                // rotate groups so weights keep cycling from the right
                for (int k = NG - 1; k > 0; k--) begin
                    n_sums[k] = r_sums[k-1];
                end
                n_sums[0] = r_sums[NG-1] + SW'(w_dval);
                n_dcnt    = r_dcnt + CW'(1);
                n_phase   = PH_DIGITS;
            end
        end
    end

    // fold lower case before the snapshot
    always_comb begin
        w_upper = n_check;
        if (n_check >= rutcdv_pkg::CH_LOW_A && n_check <= rutcdv_pkg::CH_LOW_Z) begin
            w_upper = n_check - rutcdv_pkg::CASE_DIFF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_dcnt  <= '0;
            r_check <= '0;
            for (int k = 0; k < NG; k++) begin
                r_sums[k] <= '0;
            end
        end else if (w_accept) begin
            if (i_in.last) begin
                // string finished: start over for the next one
                r_phase <= PH_START;
                r_dcnt  <= '0;
                r_check <= '0;
                for (int k = 0; k < NG; k++) begin
                    r_sums[k] <= '0;
                end
            end else begin
                r_phase <= n_phase;
                r_dcnt  <= n_dcnt;
                r_check <= n_check;
                r_sums  <= n_sums;
            end
        end
    end

    // weighted sum of the snapshot, weights 2..7
    always_comb begin
        w_wsum = '0;
        for (int k = 0; k < NG; k++) begin
            w_wsum = w_wsum + WW'(k + 2) * WW'(r_s1_sums[k]);
        end
    end

    // mod 11: reciprocal quotient, then one correction
    assign w_prod    = PW'(r_s2_wsum) * PW'(rutcdv_pkg::RECIP);
    assign w_quot    = WW'(w_prod >> rutcdv_pkg::RECIP_SHIFT);
    assign w_rem_raw = 5'(r_s2_wsum - w_quot * WW'(11));
    always_comb begin
        if (w_rem_raw >= 5'd11) begin
            w_rem = 4'(w_rem_raw - 5'd11);
        end else begin
            w_rem = w_rem_raw[3:0];
        end
        if (!r_s2_ok || w_rem == 4'd0) begin
            w_cv = 4'd0;
        end else begin
            w_cv = 4'd11 - w_rem;
        end
        if (w_cv == 4'd10) begin
            w_expect = rutcdv_pkg::CH_K;
        end else begin
            w_expect = rutcdv_pkg::CH_ZERO + 8'(w_cv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid  <= w_accept && i_in.last;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    // payload stages, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_ok    <= (n_phase == PH_DONE);
            r_s1_sums  <= n_sums;
            r_s1_check <= w_upper;

            r_s2_ok    <= r_s1_ok;
            r_s2_wsum  <= w_wsum;
            r_s2_check <= r_s1_check;

            r_out.format_ok   <= r_s2_ok;
            r_out.check_value <= w_cv;
            r_out.valid_res   <= r_s2_ok && (r_s2_check == w_expect);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // digit count never runs past the limit
    a_dcnt_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dcnt <= CW'(rutcdv_pkg::MAX_DIGITS))
        else $error("digit count beyond limit");

    // a last beat sends the parser back to start
    a_last_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in.last) |=>
            (r_phase == PH_START && r_dcnt == '0))
        else $error("parser not restarted after last beat");

    // a match implies a good format
    a_match_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.valid_res) |-> o_out.format_ok)
        else $error("match without format");

    // bad format reports check value zero, good format at most ten
    a_cv_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.format_ok ? (o_out.check_value <= 4'd10)
                                         : (o_out.check_value == 4'd0)))
        else $error("check value out of range");

    // with no stall after the edge taking a last beat, the result register fills and o_out_valid rises
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in.last) ##1 o_in_ready ##1 o_in_ready
            |=> o_out_valid)
        else $error("result missing after last beat");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// testbench for rut_check_digit_validator: directed and random identifier strings
// scored against a behavioral predictor; depends on rutcdv_pkg and the block rtl
module tb_top;

    typedef rutcdv_pkg::t_in_beat  t_in_beat;
    typedef rutcdv_pkg::t_out_beat t_out_beat;

    localparam int         MAX_DIGITS = rutcdv_pkg::MAX_DIGITS;
    localparam logic [7:0] CH_PLUS    = rutcdv_pkg::CH_PLUS;
    localparam logic [7:0] CH_MINUS   = rutcdv_pkg::CH_MINUS;
    localparam logic [7:0] CH_DOT     = rutcdv_pkg::CH_DOT;
    localparam logic [7:0] CH_SPACE   = rutcdv_pkg::CH_SPACE;
    localparam logic [7:0] CH_ZERO    = rutcdv_pkg::CH_ZERO;
    localparam logic [7:0] CH_NINE    = rutcdv_pkg::CH_NINE;
    localparam logic [7:0] CH_K       = rutcdv_pkg::CH_K;
    localparam logic [7:0] CH_LOW_A   = rutcdv_pkg::CH_LOW_A;
    localparam logic [7:0] CH_LOW_Z   = rutcdv_pkg::CH_LOW_Z;
    localparam logic [7:0] CASE_DIFF  = rutcdv_pkg::CASE_DIFF;

    localparam int STALL_LIMIT  = 5000;  // cycles with no beat on either side
    localparam int DRAIN_CYCLES = 12;    // pipe is 3 deep, leave some margin

    typedef logic [7:0] t_byte_q [$];

    // parser phases of the predictor, same order as the block's encoding
    typedef enum logic [2:0] {
        PH_START,
        PH_SIGNED,
        PH_DIGITS,
        PH_HYPHEN,
        PH_DONE,
        PH_ERROR
    } t_rut_phase;

    logic      clk      = 1'b0;
    logic      rst_n    = 1'b0;
    logic      in_valid = 1'b0;
    t_in_beat  in_beat  = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_beat out_beat;

    // predictor state
    t_rut_phase rut_phase;
    logic [7:0] group_sum [6];
    logic [4:0] digits_seen;
    logic [7:0] check_seen;
    t_out_beat  rut_results [$];

    // idling knobs, percent per cycle
    int send_idle_now = 0;
    int out_stall_now = 0;

    int err_count     = 0;
    int beats_sent    = 0;
    int strings_sent  = 0;
    int results_seen  = 0;
    int stall_cycles  = 0;

    rut_check_digit_validator dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_beat)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // 11 - (sum mod 11), where 11 folds to 0; 10 stands for K
    function automatic logic [3:0] mod11_check(int unsigned wsum);
        int unsigned v;
        v = 11 - (wsum % 11);
        if (v == 11) begin
            v = 0;
        end
        return v[3:0];
    endfunction

    function automatic logic [7:0] check_char_of(logic [3:0] v);
        return (v == 4'd10) ? CH_K : CH_ZERO + {4'd0, v};
    endfunction

    function automatic void clear_rut_state();
        rut_phase = PH_START;
        foreach (group_sum[k]) begin
            group_sum[k] = '0;
        end
        digits_seen = '0;
        check_seen  = '0;
    endfunction

    // rotate the group sums one place; the wrapped entry picks up the digit
    function automatic void take_digit(logic [7:0] c);
        logic [7:0] wrap;
        if (digits_seen >= MAX_DIGITS) begin
            rut_phase = PH_ERROR;
            return;
        end
        wrap = group_sum[5];
        for (int k = 5; k > 0; k--) begin
            group_sum[k] = group_sum[k - 1];
        end
        group_sum[0] = wrap + (c - CH_ZERO);
        digits_seen  = digits_seen + 5'd1;
        rut_phase    = PH_DIGITS;
    endfunction

    // advance the predictor by one accepted beat; queue a result on last
    function automatic void predict_beat(t_in_beat b);
        logic        is_digit;
        logic [7:0]  got;
        int unsigned wsum;
        t_out_beat   r;
        is_digit = (b.char_in >= CH_ZERO) && (b.char_in <= CH_NINE);
        // dots and spaces are skipped in every phase
        if (b.char_in != CH_DOT && b.char_in != CH_SPACE) begin
            case (rut_phase)
                PH_START: begin
                    if (b.char_in == CH_PLUS) begin
                        rut_phase = PH_SIGNED;
                    end else if (is_digit) begin
                        take_digit(b.char_in);
                    end else begin
                        rut_phase = PH_ERROR;
                    end
                end
                PH_SIGNED: begin
                    if (is_digit) begin
                        take_digit(b.char_in);
                    end else begin
                        rut_phase = PH_ERROR;
                    end
                end
                PH_DIGITS: begin
                    if (is_digit) begin
                        take_digit(b.char_in);
                    end else if (b.char_in == CH_MINUS) begin
                        rut_phase = PH_HYPHEN;
                    end else begin
                        rut_phase = PH_ERROR;
                    end
                end
                PH_HYPHEN: begin
                    check_seen = b.char_in;
                    rut_phase  = PH_DONE;
                end
                PH_DONE: begin
                end
                default: begin
                    rut_phase = PH_ERROR;
                end
            endcase
        end
        if (b.last) begin
            r           = '0;
            r.format_ok = (rut_phase == PH_DONE);
            if (r.format_ok) begin
                wsum = 0;
                for (int k = 0; k < 6; k++) begin
                    wsum += (k + 2) * group_sum[k];
                end
                r.check_value = mod11_check(wsum);
                got = check_seen;
                if (got >= CH_LOW_A && got <= CH_LOW_Z) begin
                    got = got - CASE_DIFF;
                end
                r.valid_res = (got == check_char_of(r.check_value));
            end
            rut_results.push_back(r);
            clear_rut_state();
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_byte_q to_bytes(string s);
        t_byte_q q;
        foreach (s[i]) begin
            q.push_back(s[i]);
        end
        return q;
    endfunction

    // append '-' and the correct check character; weights 2..7 from the right
    function automatic t_byte_q rut_text(t_byte_q body);
        t_byte_q     s;
        int unsigned wsum;
        int          pos;
        s    = body;
        wsum = 0;
        pos  = 0;
        for (int i = body.size() - 1; i >= 0; i--) begin
            if (body[i] >= CH_ZERO && body[i] <= CH_NINE) begin
                wsum += (body[i] - CH_ZERO) * (2 + pos % 6);
                pos++;
            end
        end
        s.push_back(CH_MINUS);
        s.push_back(check_char_of(mod11_check(wsum)));
        return s;
    endfunction

    // one beat: optional idle gap, then hold valid until accepted
    task automatic send_beat(t_in_beat b);
        while ($urandom_range(99) < send_idle_now) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        beats_sent++;
        predict_beat(b);
    endtask

    task automatic send_chars(t_byte_q s);
        t_in_beat b;
        foreach (s[i]) begin
            b.char_in = s[i];
            b.last    = (i == s.size() - 1);
            send_beat(b);
        end
        strings_sent++;
    endtask

    task automatic report_mismatch(string what, int got, int want);
        err_count++;
        $display("mismatch: %s got %0d want %0d (result %0d)", what, got, want,
                 results_seen);
    endtask

    // ------------------------------------------------------------------
    // output side: random ready, scoreboard, watchdog
    // ------------------------------------------------------------------

    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= out_stall_now);
    end

    // compare each result beat against the oldest predicted one
    always @(posedge clk) begin
        t_out_beat want;
        if (rst_n && out_valid && out_ready) begin
            if (rut_results.size() == 0) begin
                report_mismatch("result with nothing pending", int'(out_beat), 0);
            end else begin
                want = rut_results.pop_front();
                if (out_beat.valid_res !== want.valid_res) begin
                    report_mismatch("valid_res", int'(out_beat.valid_res),
                                    int'(want.valid_res));
                end
                if (out_beat.format_ok !== want.format_ok) begin
                    report_mismatch("format_ok", int'(out_beat.format_ok),
                                    int'(want.format_ok));
                end
                if (out_beat.check_value !== want.check_value) begin
                    report_mismatch("check_value", int'(out_beat.check_value),
                                    int'(want.check_value));
                end
            end
            results_seen++;
        end
    end

    // end the run if neither channel moves a beat for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no beat for %0d cycles, %0d results pending",
                     STALL_LIMIT, rut_results.size());
            $display("tb: failure");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // well-formed numbers, letter K in both cases, zero, longest run, sign, wrong check char, ignored tail
    task automatic test_valid_numbers();
        send_chars(rut_text(to_bytes("0")));              // all zero, check 0
        send_chars(rut_text(to_bytes("0007")));           // leading zeros
        send_chars(rut_text(to_bytes("9999999999")));     // longest digit run
        send_chars(rut_text(to_bytes("+ 12.345.678")));   // sign, dots, spaces
        send_chars(to_bytes("6-K"));                      // check value ten
        send_chars(to_bytes("6-k"));                      // lower-case letter
        send_chars(to_bytes("6-0"));                      // wrong check char
        send_chars(to_bytes("6-Kzz."));                   // tail is ignored
        send_chars('{CH_ZERO + 8'd1, CH_MINUS, 8'hFF});   // top byte as check
    endtask

    // ways the format can break
    task automatic test_format_errors();
        send_chars(to_bytes("-6-K"));                     // minus sign
        send_chars(to_bytes("12345678901-1"));            // too many digits
        send_chars(to_bytes("12a-3"));                    // bad separator
        send_chars(to_bytes("123"));                      // ends in digits
        send_chars(to_bytes("12 3-"));                    // ends at hyphen
        send_chars(to_bytes("+-1"));                      // sign then hyphen
        send_chars(to_bytes("1+2-3"));                    // sign after digits
        send_chars('{8'h00});                             // lone zero byte
        send_chars('{8'hFF, CH_ZERO, CH_MINUS, CH_ZERO}); // error then ignored
        send_chars(to_bytes(". ."));                      // only skipped chars
    endtask

    // mostly well-formed numbers with random content, plus noise and damage
    task automatic test_random_strings(int send_pct, int stall_pct, int n_beats);
        t_byte_q body;
        t_byte_q s;
        int      stop_at;
        int      n;
        int      pos;
        stop_at = beats_sent + n_beats;
        while (beats_sent < stop_at) begin
            // now and then a whole string with no idling at all
            if ($urandom_range(4) == 0) begin
                send_idle_now = 0;
                out_stall_now = 0;
            end else begin
                send_idle_now = send_pct;
                out_stall_now = stall_pct;
            end
            body.delete();
            s.delete();
            if ($urandom_range(99) < 15) begin
                // raw byte noise
                n = $urandom_range(1, 6);
                repeat (n) begin
                    s.push_back(8'($urandom_range(255)));
                end
            end else begin
                if ($urandom_range(3) == 0) begin
                    body.push_back(CH_PLUS);
                end
                n = ($urandom_range(19) == 0) ? $urandom_range(MAX_DIGITS + 1, MAX_DIGITS + 3)
                                              : $urandom_range(1, MAX_DIGITS);
                repeat (n) begin
                    if ($urandom_range(7) == 0) begin
                        body.push_back($urandom_range(1) ? CH_DOT : CH_SPACE);
                    end
                    body.push_back(CH_ZERO + 8'($urandom_range(9)));
                end
                s   = rut_text(body);
                pos = s.size() - 1;
                n   = $urandom_range(99);
                if (n < 70) begin
                    if (s[pos] == CH_K && $urandom_range(1)) begin
                        s[pos] = CH_K + CASE_DIFF;
                    end
                end else if (n < 90) begin
                    n      = $urandom_range(10);
                    s[pos] = (n == 10) ? CH_K : CH_ZERO + 8'(n);
                end else begin
                    s[pos] = 8'($urandom_range(255));
                end
                if ($urandom_range(9) == 0) begin
                    repeat ($urandom_range(1, 3)) begin
                        s.push_back(8'($urandom_range(255)));
                    end
                end
                // damage: overwrite, drop, or cut short
                if ($urandom_range(9) == 0) begin
                    pos = $urandom_range(s.size() - 1);
                    case ($urandom_range(2))
                        0: s[pos] = 8'($urandom_range(255));
                        1: if (s.size() > 1) begin
                            s.delete(pos);
                        end
                        default: s = s[0:pos];
                    endcase
                end
            end
            send_chars(s);
        end
    endtask

    initial begin
        clear_rut_state();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_valid_numbers();
        test_format_errors();
        test_random_strings(0, 0, 315);
        test_random_strings(63, 0, 315);
        test_random_strings(0, 63, 315);
        test_random_strings(38, 38, 315);

        // all stimulus accepted; drain the results
        in_valid      <= 1'b0;
        send_idle_now = 0;
        out_stall_now = 0;
        while (rut_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d strings, %0d characters, %0d results checked, %0d errors",
                 strings_sent, beats_sent, results_seen, err_count);
        $display("idling mixes: none, sender 63%%, receiver 63%%, both 38%%");
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== rut_check_digit_validator.f =====
rtl/rutcdv_pkg.sv
rtl/rut_check_digit_validator.sv
test/tb_top.sv
